// File: hw/rtl/ptfr_pkg.sv
// Shared constants, field widths, codes and sequencer states for the page translation block.
package ptfr_pkg;

  localparam int PROCESS_COUNT_DEF = 16;
  localparam int PAGE_COUNT_DEF    = 256;
  localparam int FRAME_COUNT_DEF   = 16;
  localparam int PAGE_BYTES_DEF    = 256;

  localparam int PROC_ID_W  = 4;
  localparam int VADDR_W    = 16;
  localparam int PADDR_W    = 12;
  localparam int STATUS_W   = 3;
  localparam int EV_PAGE_W  = 8;
  localparam int MASK_W     = 16;

  typedef enum logic {
    ACT_TRANSLATE = 1'b0,
    ACT_UNMAP     = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MAPPED   = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_REJECTED = 3'd3,
    ST_UNMAPPED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_EVICT,
    S_COMMIT
  } seq_state_t;

endpackage

// File: hw/rtl/ptfr_if.sv
// Request and response channel interfaces with valid/ready handshake.
interface ptfr_req_if
  import ptfr_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [PROC_ID_W-1:0] process_id;
  logic [VADDR_W-1:0]   virtual_address;

  modport source (output valid, action, process_id, virtual_address, input ready);
  modport sink   (input valid, action, process_id, virtual_address, output ready);
endinterface

interface ptfr_rsp_if
  import ptfr_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [PADDR_W-1:0]   physical_address;
  logic [STATUS_W-1:0]  status;
  logic [PROC_ID_W-1:0] evicted_process;
  logic [EV_PAGE_W-1:0] evicted_page;

  modport source (output valid, physical_address, status, evicted_process, evicted_page,
                  input ready);
  modport sink   (input valid, physical_address, status, evicted_process, evicted_page,
                  output ready);
endinterface

// File: hw/rtl/ptfr_map_ram.sv
// Single-port-write, single-port-read page map memory with registered read data.
module ptfr_map_ram
  import ptfr_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 5,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/paged_translation_fifo_replacement.sv
// Per-process page translation with in-order first-fill frame allocation and FIFO frame eviction.
// Sequence: a request is accepted in S_IDLE and resolved in S_LOOKUP into the output register;
//   on eviction it goes on through S_EVICT to S_COMMIT; S_LOOKUP and S_COMMIT wait while the output is held.
//   No new request is taken before S_IDLE, as the page map read-modify-write must finish first.
// Reset: after rst_n a clearing pass writes every page map entry invalid, one per cycle,
//   PROCESS_COUNT(max 16) * PAGE_COUNT entries (4096 by default); no request is taken meanwhile.
// PAGE_BYTES must be a power of two.
module paged_translation_fifo_replacement
  import ptfr_pkg::*;
#(
  parameter int PROCESS_COUNT = PROCESS_COUNT_DEF,
  parameter int PAGE_COUNT    = PAGE_COUNT_DEF,
  parameter int FRAME_COUNT   = FRAME_COUNT_DEF,
  parameter int PAGE_BYTES    = PAGE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ptfr_req_if.sink          in_req,
  ptfr_rsp_if.source        out_rsp,
  input  logic              cfg_we,
  input  logic [MASK_W-1:0] cfg_wdata
);

  localparam int ID_SPAN   = 1 << PROC_ID_W;
  localparam int MAP_PROCS = (PROCESS_COUNT < ID_SPAN) ? PROCESS_COUNT : ID_SPAN;
  localparam int MAP_DEPTH = MAP_PROCS * PAGE_COUNT;
  localparam int IDX_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int FILL_W    = $clog2(FRAME_COUNT + 1);
  localparam int MAP_W     = FRAME_W + 1;
  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int PFIELD_W  = (VADDR_W - OFF_W > 0) ? VADDR_W - OFF_W : 1;
  localparam int PG_W      = $clog2(PAGE_COUNT);

  seq_state_t state_r, state_nxt;

  logic [MASK_W-1:0]    mask_r;
  logic [IDX_W-1:0]     clr_cnt_r;
  logic [FILL_W-1:0]    filled_r;
  logic [FRAME_W-1:0]   victim_r;

  // latched request
  logic                 act_r;
  logic [PROC_ID_W-1:0] proc_r;
  logic [PG_W-1:0]      page_r;
  logic [OFF_W-1:0]     offset_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 reject_r;

  // output register
  logic                 out_valid_r;
  logic [PADDR_W-1:0]   out_pa_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [PROC_ID_W-1:0] out_ev_proc_r;
  logic [EV_PAGE_W-1:0] out_ev_page_r;

  // frame owner memory
  logic [PROC_ID_W-1:0] own_proc_mem [FRAME_COUNT];
  logic [PG_W-1:0]      own_page_mem [FRAME_COUNT];
  logic [PROC_ID_W-1:0] own_proc_rd;
  logic [PG_W-1:0]      own_page_rd;

  // page map port
  logic                 map_we, map_re;
  logic [IDX_W-1:0]     map_waddr, map_raddr;
  logic [MAP_W-1:0]     map_wdata, map_rdata;

  // control
  logic                 lat_req, own_re, own_we, out_load, filled_inc, victim_adv, out_free;
  logic [FRAME_W-1:0]   own_waddr;
  logic [FRAME_W-1:0]   res_frame;
  logic [STATUS_W-1:0]  res_status;
  logic [PROC_ID_W-1:0] res_ev_proc;
  logic [EV_PAGE_W-1:0] res_ev_page;
  logic                 res_zero_pa;

  // request decode
  logic [VADDR_W-1:0]   in_page_full;
  logic [PFIELD_W-1:0]  in_page;
  logic [31:0]          in_off_full;
  logic                 in_reject;
  logic [IDX_W-1:0]     in_idx;
  logic [IDX_W-1:0]     own_idx;
  logic [31:0]          pa_full;
  logic [31:0]          ev_page_full;
  logic                 map_rd_valid;
  logic [FRAME_W-1:0]   map_rd_frame;

  assign in_page_full = in_req.virtual_address >> OFF_W;
  assign in_page      = in_page_full[PFIELD_W-1:0];
  assign in_off_full  = 32'(in_req.virtual_address) & ((32'd1 << OFF_W) - 32'd1);
  assign in_reject    = !(32'(in_req.process_id) < PROCESS_COUNT) ||
                        !mask_r[in_req.process_id] ||
                        !(32'(in_page) < PAGE_COUNT);
  assign in_idx       = IDX_W'(32'(in_req.process_id) * PAGE_COUNT + 32'(in_page));
  assign own_idx      = IDX_W'(32'(own_proc_rd) * PAGE_COUNT + 32'(own_page_rd));
  assign map_rd_valid = map_rdata[MAP_W-1];
  assign map_rd_frame = map_rdata[FRAME_W-1:0];
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign pa_full      = (32'(res_frame) << OFF_W) | 32'(offset_r);
  assign ev_page_full = 32'(own_page_rd);

  ptfr_map_ram #(
    .DEPTH (MAP_DEPTH),
    .WIDTH (MAP_W)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_req.ready = 1'b0;
    lat_req     = 1'b0;
    map_we      = 1'b0;
    map_waddr   = idx_r;
    map_wdata   = '0;
    map_re      = 1'b0;
    map_raddr   = in_idx;
    own_re      = 1'b0;
    own_we      = 1'b0;
    own_waddr   = victim_r;
    out_load    = 1'b0;
    filled_inc  = 1'b0;
    victim_adv  = 1'b0;
    res_frame   = map_rd_frame;
    res_status  = ST_HIT;
    res_ev_proc = '0;
    res_ev_page = '0;
    res_zero_pa = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_cnt_r;
        if (clr_cnt_r == IDX_W'(MAP_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          lat_req   = 1'b1;
          map_re    = 1'b1;
          own_re    = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (out_free) begin
          if (reject_r) begin
            out_load    = 1'b1;
            res_status  = ST_REJECTED;
            res_zero_pa = 1'b1;
            state_nxt   = S_IDLE;
          end else if (act_r == ACT_UNMAP) begin
            map_we      = 1'b1;
            out_load    = 1'b1;
            res_status  = ST_UNMAPPED;
            res_zero_pa = 1'b1;
            state_nxt   = S_IDLE;
          end else if (map_rd_valid) begin
            out_load   = 1'b1;
            res_status = ST_HIT;
            state_nxt  = S_IDLE;
          end else if (32'(filled_r) < FRAME_COUNT) begin
            res_frame  = FRAME_W'(filled_r);
            map_we     = 1'b1;
            map_wdata  = {1'b1, res_frame};
            own_we     = 1'b1;
            own_waddr  = res_frame;
            filled_inc = 1'b1;
            out_load   = 1'b1;
            res_status = ST_MAPPED;
            state_nxt  = S_IDLE;
          end else begin
            // look up the victim owner's entry before touching our own
            map_re    = 1'b1;
            map_raddr = own_idx;
            state_nxt = S_EVICT;
          end
        end
      end
      S_EVICT: begin
        if (map_rd_valid && map_rd_frame == victim_r) begin
          map_we    = 1'b1;
          map_waddr = own_idx;
        end
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          res_frame   = victim_r;
          map_we      = 1'b1;
          map_wdata   = {1'b1, victim_r};
          own_we      = 1'b1;
          own_waddr   = victim_r;
          victim_adv  = 1'b1;
          out_load    = 1'b1;
          res_status  = ST_EVICTED;
          res_ev_proc = own_proc_rd;
          res_ev_page = ev_page_full[EV_PAGE_W-1:0];
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      clr_cnt_r   <= '0;
      filled_r    <= '0;
      victim_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (filled_inc) begin
        filled_r <= filled_r + FILL_W'(1);
      end
      if (victim_adv) begin
        victim_r <= (victim_r == FRAME_W'(FRAME_COUNT - 1)) ? '0 : victim_r + FRAME_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (lat_req) begin
      act_r    <= in_req.action;
      proc_r   <= in_req.process_id;
      page_r   <= PG_W'(in_page);
      offset_r <= in_off_full[OFF_W-1:0];
      idx_r    <= in_idx;
      reject_r <= in_reject;
    end
    if (out_load) begin
      out_pa_r      <= res_zero_pa ? '0 : pa_full[PADDR_W-1:0];
      out_status_r  <= res_status;
      out_ev_proc_r <= res_ev_proc;
      out_ev_page_r <= res_ev_page;
    end
  end

  // frame owner memory, read at the FIFO head when a word is taken
  always_ff @(posedge clk) begin
    if (own_we) begin
      own_proc_mem[own_waddr] <= proc_r;
      own_page_mem[own_waddr] <= page_r;
    end
    if (own_re) begin
      own_proc_rd <= own_proc_mem[victim_r];
      own_page_rd <= own_page_mem[victim_r];
    end
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.physical_address = out_pa_r;
  assign out_rsp.status           = out_status_r;
  assign out_rsp.evicted_process  = out_ev_proc_r;
  assign out_rsp.evicted_page     = out_ev_page_r;

endmodule

// File: bench/paged_translation_fifo_replacement_tb.sv
// Self-checking testbench for per-process page translation with FIFO frame replacement.
`timescale 1ns / 1ps

module paged_translation_fifo_replacement_tb;
  import ptfr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAP_DEPTH   = 4096;
  localparam int FRAMES      = 16;

  typedef struct packed {
    action_t              action;
    logic [PROC_ID_W-1:0] pid;
    logic [VADDR_W-1:0]   va;
  } xlat_req_t;

  typedef struct packed {
    logic [PADDR_W-1:0]   pa;
    status_t              status;
    logic [PROC_ID_W-1:0] ev_proc;
    logic [EV_PAGE_W-1:0] ev_page;
  } xlat_rsp_t;

  typedef struct {
    bit                wr_mask;
    logic [MASK_W-1:0] mask;
    xlat_req_t         word;
    bit                typed;
    xlat_rsp_t         exp;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  ptfr_req_if in_req ();
  ptfr_rsp_if out_rsp ();

  paged_translation_fifo_replacement dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the translation state
  bit [MASK_W-1:0]    active_mask;
  bit                 map_valid [MAP_DEPTH];
  bit [3:0]           map_frame [MAP_DEPTH];
  bit                 own_valid [FRAMES];
  bit [PROC_ID_W-1:0] own_proc  [FRAMES];
  bit [EV_PAGE_W-1:0] own_page  [FRAMES];
  int                 frames_handed;
  bit [3:0]           victim_ptr;

  xlat_rsp_t pending_translations[$];
  dir_row_t  directed_rows[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        snd_idle_pct = 0;
  int        rcv_idle_pct = 0;
  bit        stall_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic xlat_rsp_t translate_request(xlat_req_t w);
    xlat_rsp_t          r;
    logic [7:0]         page;
    logic [7:0]         offset;
    logic [11:0]        idx;
    logic [11:0]        old_idx;
    logic [3:0]         frame;
    r = '0;
    page = w.va[15:8];
    offset = w.va[7:0];
    idx = {w.pid, page};
    if (!active_mask[w.pid]) begin
      r.status = ST_REJECTED;
      return r;
    end
    if (w.action == ACT_UNMAP) begin
      map_valid[idx] = 1'b0;
      map_frame[idx] = '0;
      r.status = ST_UNMAPPED;
      return r;
    end
    if (map_valid[idx]) begin
      r.pa = {map_frame[idx], offset};
      r.status = ST_HIT;
      return r;
    end
    if (frames_handed < FRAMES) begin
      frame = frames_handed[3:0];
      frames_handed++;
      r.status = ST_MAPPED;
    end else begin
      frame = victim_ptr;
      victim_ptr = victim_ptr + 4'd1;
      r.status = ST_EVICTED;
      if (own_valid[frame]) begin
        r.ev_proc = own_proc[frame];
        r.ev_page = own_page[frame];
        old_idx = {own_proc[frame], own_page[frame]};
        // leave a stale owner alone
        if (map_valid[old_idx] && map_frame[old_idx] == frame) begin
          map_valid[old_idx] = 1'b0;
          map_frame[old_idx] = '0;
        end
      end
    end
    map_valid[idx] = 1'b1;
    map_frame[idx] = frame;
    own_valid[frame] = 1'b1;
    own_proc[frame] = w.pid;
    own_page[frame] = page;
    r.pa = {frame, offset};
    return r;
  endfunction

  task automatic send_word(input xlat_req_t w, input bit typed, input xlat_rsp_t typed_exp);
    xlat_rsp_t pred;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.action <= w.action;
    in_req.process_id <= w.pid;
    in_req.virtual_address <= w.va;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    pred = translate_request(w);
    pending_translations.push_back(typed ? typed_exp : pred);
  endtask

  task automatic drain_all();
    in_req.valid <= 1'b0;
    while (pending_translations.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] m);
    drain_all();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_mask = m;
  endtask

  function automatic void add_mask_row(input logic [MASK_W-1:0] m);
    dir_row_t r;
    r.wr_mask = 1'b1;
    r.mask = m;
    r.word = '0;
    r.typed = 1'b0;
    r.exp = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_row(input action_t a, input logic [3:0] p, input logic [15:0] va,
                                  input bit typed, input logic [11:0] pa, input status_t st,
                                  input logic [3:0] ep, input logic [7:0] eg);
    dir_row_t r;
    r.wr_mask = 1'b0;
    r.mask = '0;
    r.word.action = a;
    r.word.pid = p;
    r.word.va = va;
    r.typed = typed;
    r.exp.pa = pa;
    r.exp.status = st;
    r.exp.ev_proc = ep;
    r.exp.ev_page = eg;
    directed_rows.push_back(r);
  endfunction

  // Receive side: check each word against the oldest expectation
  initial begin
    xlat_rsp_t exp;
    int        hold_left;
    bit        hold_done;
    out_rsp.ready <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
        if (pending_translations.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: pa=%h st=%0d evp=%0d evg=%h", out_rsp.physical_address,
                     out_rsp.status, out_rsp.evicted_process, out_rsp.evicted_page);
        end else begin
          exp = pending_translations.pop_front();
          if (exp.pa !== out_rsp.physical_address || exp.status !== out_rsp.status ||
              exp.ev_proc !== out_rsp.evicted_process || exp.ev_page !== out_rsp.evicted_page) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp pa=%h st=%0d evp=%0d evg=%h, got pa=%h st=%0d evp=%0d evg=%h",
                       exp.pa, exp.status, exp.ev_proc, exp.ev_page, out_rsp.physical_address,
                       out_rsp.status, out_rsp.evicted_process, out_rsp.evicted_page);
          end
        end
      end
      if (stall_request && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      // hold off long enough to back the block up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_rsp.ready <= 1'b0;
      end else begin
        out_rsp.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  initial begin
    xlat_req_t       w;
    logic [MASK_W-1:0] m;
    logic [3:0]      proc_pool [4];
    logic [7:0]      page_pool [8];
    int              seg_len;
    int              pick;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_req.valid <= 1'b0;
    in_req.action <= 1'b0;
    in_req.process_id <= '0;
    in_req.virtual_address <= '0;
    active_mask = '0;
    frames_handed = 0;
    victim_ptr = '0;

    // mask still at reset: everything is rejected
    add_row(ACT_TRANSLATE, 4'd0, 16'h0000, 1, 12'h000, ST_REJECTED, 4'd0, 8'h00);
    add_row(ACT_TRANSLATE, 4'd15, 16'hFFFF, 1, 12'h000, ST_REJECTED, 4'd0, 8'h00);
    add_mask_row(16'hFFFF);
    add_row(ACT_TRANSLATE, 4'd0, 16'h0000, 1, 12'h000, ST_MAPPED, 4'd0, 8'h00);
    add_row(ACT_TRANSLATE, 4'd0, 16'h00FF, 1, 12'h0FF, ST_HIT, 4'd0, 8'h00);
    add_row(ACT_TRANSLATE, 4'd15, 16'hFFFF, 1, 12'h1FF, ST_MAPPED, 4'd0, 8'h00);
    add_row(ACT_UNMAP, 4'd15, 16'hFF00, 1, 12'h000, ST_UNMAPPED, 4'd0, 8'h00);
    // unmap of an entry that is already invalid
    add_row(ACT_UNMAP, 4'd15, 16'hFF00, 1, 12'h000, ST_UNMAPPED, 4'd0, 8'h00);
    // frame 1 stays held, so the remap takes frame 2
    add_row(ACT_TRANSLATE, 4'd15, 16'hFF80, 1, 12'h280, ST_MAPPED, 4'd0, 8'h00);
    for (int i = 0; i < 13; i++)
      add_row(ACT_TRANSLATE, 4'd1, {i[7:0], 8'($urandom_range(0, 255))}, 0, '0, ST_HIT, '0, '0);
    add_row(ACT_TRANSLATE, 4'd2, 16'h0010, 1, 12'h010, ST_EVICTED, 4'd0, 8'h00);
    // frame 1 owner was remapped elsewhere: reported but left alone
    add_row(ACT_TRANSLATE, 4'd0, 16'h0000, 1, 12'h100, ST_EVICTED, 4'd15, 8'hFF);
    add_row(ACT_TRANSLATE, 4'd15, 16'hFF01, 1, 12'h201, ST_HIT, 4'd0, 8'h00);
    add_mask_row(16'h8001);
    add_row(ACT_TRANSLATE, 4'd1, 16'h0005, 1, 12'h000, ST_REJECTED, 4'd0, 8'h00);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 11;
    rcv_idle_pct = 68;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].wr_mask)
        write_mask(directed_rows[i].mask);
      else
        send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].exp);
    end

    for (int seg = 0; seg < 8; seg++) begin
      if (seg < 3) begin
        snd_idle_pct = 11;
        rcv_idle_pct = 68;
      end else if (seg < 6) begin
        snd_idle_pct = 68;
        rcv_idle_pct = 11;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (seg)
        2, 5, 7: m = 16'($urandom_range(0, 65535)) | 16'h8001;
        3:       m = 16'h0000;
        4:       m = 16'h8001;
        default: m = 16'hFFFF;
      endcase
      seg_len = (seg == 3) ? 20 : 226;
      write_mask(m);
      if (seg == 6)
        stall_request = 1'b1;
      for (int i = 0; i < 4; i++)
        proc_pool[i] = 4'($urandom_range(0, 15));
      proc_pool[0] = 4'd0;
      proc_pool[1] = 4'd15;
      for (int i = 0; i < 8; i++)
        page_pool[i] = 8'($urandom_range(0, 255));
      for (int n = 0; n < seg_len; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          w.action = action_t'($urandom_range(0, 1));
          w.pid = 4'($urandom_range(0, 15));
          w.va = 16'($urandom_range(0, 65535));
        end else begin
          // small working set: mix of hits, fills, evictions and unmaps
          w.action = (pick < 20) ? ACT_UNMAP : ACT_TRANSLATE;
          w.pid = proc_pool[$urandom_range(0, 3)];
          w.va = {page_pool[$urandom_range(0, 7)], 8'($urandom_range(0, 255))};
        end
        send_word(w, 1'b0, '0);
      end
    end

    drain_all();
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
